### rtl/core/raster_to_page_bitmap_converter_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef RASTER_TO_PAGE_BITMAP_CONVERTER_ASSERT_SVH
`define RASTER_TO_PAGE_BITMAP_CONVERTER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define RPBC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RPBC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/rpbc_pkg.sv
// Shared types and constants for the raster to page bitmap converter.
package rpbc_pkg;

  localparam int unsigned StripRows = 8;
  localparam logic [2:0]  LastIdx   = 3'd7;
  localparam int unsigned ColHiW    = 4;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] page_byte;
    logic [6:0] column;
    logic [2:0] page;
    logic       last_of_run;
    logic       frame_end;
  } out_t;

  // One transposed 8x8 block: cols[i] is the page byte for pixel column 8c+i.
  typedef struct packed {
    logic [7:0][7:0]    cols;
    logic [ColHiW-1:0]  col_hi;
    logic [2:0]         page;
    logic               frame_end;
  } blk_t;

endpackage

### rtl/core/rpbc_ram.sv
// Generic simple dual-port RAM with registered read.
module rpbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rpbc_strip.sv
// Raster position tracking, strip row store and 8x8 block transpose.
module rpbc_strip #(
  parameter int unsigned ROW_BYTES  = 16,
  parameter int unsigned FRAME_ROWS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  rpbc_pkg::in_t  in_data_i,
  output logic           blk_valid_o,
  output rpbc_pkg::blk_t blk_o
);

  localparam int unsigned CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int unsigned RW = $clog2(FRAME_ROWS);

  logic [CW-1:0] col_q, col_cur;
  logic [RW-1:0] row_q, row_cur;
  logic [2:0]    srow;
  logic          last_col, last_row, emit;

  logic                           s1_valid_q;
  logic [7:0]                     s1_px_q;
  logic [rpbc_pkg::ColHiW-1:0]    s1_col_q;
  logic [2:0]                     s1_page_q;
  logic                           s1_fe_q;
  logic [7:0]                     rdata [7];
  logic [7:0]                     rows [8];

  assign col_cur  = in_data_i.frame_start ? '0 : col_q;
  assign row_cur  = in_data_i.frame_start ? '0 : row_q;
  assign srow     = row_cur[2:0];
  assign last_col = (col_cur == CW'(ROW_BYTES - 1));
  assign last_row = (row_cur == RW'(FRAME_ROWS - 1));
  assign emit     = acc_i && (srow == rpbc_pkg::LastIdx);

  for (genvar r = 0; r < 7; r++) begin : g_row
    rpbc_ram #(
      .Width(8),
      .Depth(ROW_BYTES)
    ) u_row_ram (
      .clk_i  (clk_i),
      .we_i   (acc_i && (srow == 3'(r))),
      .waddr_i(col_cur),
      .wdata_i(in_data_i.pixel_byte),
      .re_i   (emit),
      .raddr_i(col_cur),
      .rdata_o(rdata[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= emit;
      if (acc_i) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_cur + RW'(1);
        end else begin
          col_q <= col_cur + CW'(1);
          row_q <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_px_q   <= in_data_i.pixel_byte;
      s1_col_q  <= rpbc_pkg::ColHiW'(col_cur);
      s1_page_q <= 3'(row_cur >> 3);
      s1_fe_q   <= ((row_cur >> 3) == RW'(FRAME_ROWS / 8 - 1)) && last_col;
    end
  end

  always_comb begin
    for (int r = 0; r < 7; r++) begin
      rows[r] = rdata[r];
    end
    rows[7] = s1_px_q;
    blk_o.col_hi    = s1_col_q;
    blk_o.page      = s1_page_q;
    blk_o.frame_end = s1_fe_q;
    for (int i = 0; i < 8; i++) begin
      for (int r = 0; r < 8; r++) begin
        blk_o.cols[i][r] = rows[r][7 - i];
      end
    end
  end

  assign blk_valid_o = s1_valid_q;

endmodule

### rtl/core/rpbc_blkq.sv
// Block queue and page byte serializer.
module rpbc_blkq #(
  parameter int unsigned DEPTH = 18
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpbc_pkg::blk_t blk_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rpbc_pkg::out_t out_data_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            rd_en, f_valid_q, f_take, ob_valid_q, ob_done;
  logic [2:0]      idx_q;
  rpbc_pkg::blk_t  rdata, ob_q;

  rpbc_ram #(
    .Width($bits(rpbc_pkg::blk_t)),
    .Depth(DEPTH)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (push_i),
    .waddr_i(wr_ptr_q),
    .wdata_i(blk_i),
    .re_i   (rd_en),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign full_o  = ((CNTW + 1)'(count_q) + (CNTW + 1)'(push_i)) >= (CNTW + 1)'(DEPTH);
  assign ob_done = ob_valid_q && !out_stall_i && (idx_q == rpbc_pkg::LastIdx);
  assign f_take  = f_valid_q && (!ob_valid_q || ob_done);
  assign rd_en   = (count_q != '0) && (!f_valid_q || f_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      f_valid_q  <= 1'b0;
      ob_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CNTW'(push_i) - CNTW'(rd_en);
      if (rd_en) begin
        f_valid_q <= 1'b1;
      end else if (f_take) begin
        f_valid_q <= 1'b0;
      end
      if (f_take) begin
        ob_valid_q <= 1'b1;
        idx_q      <= '0;
      end else if (ob_valid_q && !out_stall_i) begin
        if (idx_q == rpbc_pkg::LastIdx) begin
          ob_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_take) begin
      ob_q <= rdata;
    end
  end

  always_comb begin
    out_data_o.page_byte   = ob_q.cols[idx_q];
    out_data_o.column      = {ob_q.col_hi, idx_q};
    out_data_o.page        = ob_q.page;
    out_data_o.last_of_run = (idx_q == rpbc_pkg::LastIdx);
    out_data_o.frame_end   = ob_q.frame_end && (idx_q == rpbc_pkg::LastIdx);
  end

  assign out_valid_o = ob_valid_q;

endmodule

### rtl/core/raster_to_page_bitmap_converter.sv
// Top level of the raster to vertical page bitmap converter.
//
//   channel  dir  handshake             beat payload
//   in       in   in_valid_i/in_stall_o   rpbc_pkg::in_t  (one raster byte)
//   out      out  out_valid_o/out_stall_i rpbc_pkg::out_t (one page byte)
//
// One raster byte is taken per cycle unless in_stall_o is high; rows 0..6 of a
// strip go to seven row RAMs. An eighth-row byte reads them, is transposed next
// cycle, and its eight page bytes leave one per cycle while out_stall_i is low,
// from a queue of ROW_BYTES+2 blocks. in_stall_o rises only when it lacks room.
// Reset clears position, queue pointers and valids; the row RAMs are not cleared.
`include "raster_to_page_bitmap_converter_assert.svh"

module raster_to_page_bitmap_converter #(
  parameter int unsigned ROW_BYTES  = 16,
  parameter int unsigned FRAME_ROWS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rpbc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rpbc_pkg::out_t out_data_o
);

  localparam int unsigned QDepth = ROW_BYTES + 2;

  logic           acc, blk_valid, q_full;
  rpbc_pkg::blk_t blk;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full;

  rpbc_strip #(
    .ROW_BYTES (ROW_BYTES),
    .FRAME_ROWS(FRAME_ROWS)
  ) u_strip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_data_i  (in_data_i),
    .blk_valid_o(blk_valid),
    .blk_o      (blk)
  );

  rpbc_blkq #(
    .DEPTH(QDepth)
  ) u_blkq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (blk_valid),
    .blk_i      (blk),
    .full_o     (q_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `RPBC_ASSERT(a_run_unbroken, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o, "page run broken")
  `RPBC_ASSERT(a_run_column_step, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_data_o.column == $past(out_data_o.column) + 7'd1, "column not consecutive")
  `RPBC_ASSERT(a_run_starts_aligned, clk_i, rst_ni,
    out_valid_o && !out_stall_i && out_data_o.last_of_run |=> !out_valid_o || out_data_o.column[2:0] == 3'd0, "run not aligned")

endmodule

### test/raster_to_page_bitmap_converter_test.sv
// Self-checking testbench for the raster to vertical page bitmap converter.
`timescale 1ns / 100ps

module raster_to_page_bitmap_converter_test;

  localparam int NumStrips   = 3;
  localparam int RandomBeats = 130;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [7:0][7:0] rows;
    logic            fs;
    logic            rnd;
    logic [7:0]      nbytes;
    logic            fixed;
    logic [7:0]      want;
  } strip_case_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  rpbc_pkg::in_t  in_data_i   = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  rpbc_pkg::out_t out_data_o;

  logic [7:0]     row_mem [0:111];
  logic [9:0]     raster_pos = '0;
  rpbc_pkg::out_t page_bytes_due [$];
  strip_case_t    strips [0:NumStrips-1];
  int             errors = 0;
  int             cycles = 0;
  logic           idle_in = 1'b0;
  logic           idle_out = 1'b0;

  raster_to_page_bitmap_converter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < 112; k++) row_mem[k] = 8'h00;
  end

  function automatic strip_case_t mk_strip(input logic [63:0] rows, input logic fs,
                                           input logic rnd, input logic [7:0] n,
                                           input logic fixed, input logic [7:0] want);
    return {rows, fs, rnd, n, fixed, want};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    errors++;
    $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, want_v, got_v, cycles);
  endtask

  // Store rows 0..6; on row 7 transpose the column's 8x8 block into page bytes.
  task automatic predict_page_bytes(input rpbc_pkg::in_t beat, input logic fix,
                                    input logic [7:0] typed);
    logic [5:0]     row;
    logic [3:0]     col;
    rpbc_pkg::out_t o;
    if (beat.frame_start) raster_pos = '0;
    row = raster_pos[9:4];
    col = raster_pos[3:0];
    if (row[2:0] != rpbc_pkg::LastIdx) begin
      row_mem[{row[2:0], col}] = beat.pixel_byte;
    end else begin
      for (int i = 0; i < 8; i++) begin
        for (int r = 0; r < 7; r++) o.page_byte[r] = row_mem[{3'(r), col}][7 - i];
        o.page_byte[7] = beat.pixel_byte[7 - i];
        o.column       = {col, 3'(i)};
        o.page         = row[5:3];
        o.last_of_run  = (i == 7);
        o.frame_end    = (i == 7) && (row[5:3] == 3'd7) && (col == 4'd15);
        if (fix) o.page_byte = typed;
        page_bytes_due.push_back(o);
      end
    end
    raster_pos = raster_pos + 10'd1;
  endtask

  task automatic check_page_byte(input rpbc_pkg::out_t got);
    rpbc_pkg::out_t want;
    if (page_bytes_due.size() == 0) begin
      report_mismatch("unexpected beat", 32'd0, 32'({got.page_byte, got.column, got.page}));
      return;
    end
    want = page_bytes_due.pop_front();
    if (got.page_byte !== want.page_byte)
      report_mismatch("page_byte", 32'(want.page_byte), 32'(got.page_byte));
    if (got.column !== want.column)
      report_mismatch("column", 32'(want.column), 32'(got.column));
    if (got.page !== want.page) report_mismatch("page", 32'(want.page), 32'(got.page));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", 32'(want.frame_end), 32'(got.frame_end));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input rpbc_pkg::in_t beat, input logic fix,
                           input logic [7:0] typed);
    int gap;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_page_bytes(beat, fix, typed);
    @(negedge clk_i);
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_out ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_page_byte(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin
    rpbc_pkg::in_t beat;
    // rows[7..0] per strip
    strips[0] = mk_strip(64'h0000_0000_0000_0000, 1'b1, 1'b0, 8'd128, 1'b1, 8'h00);
    strips[1] = mk_strip(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'd128, 1'b1, 8'hFF);
    // early frame start cuts a strip short; the random strip then overwrites it
    strips[2] = mk_strip(64'h0, 1'b1, 1'b1, 8'd40, 1'b0, 8'h00);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int e = 0; e < NumStrips; e++) begin
      idle_in  = (e % 3) != 0;
      idle_out = (e % 2) == 0;
      for (int j = 0; j < strips[e].nbytes; j++) begin
        beat.pixel_byte  = strips[e].rnd ? 8'($urandom_range(0, 255)) : strips[e].rows[j / 16];
        beat.frame_start = strips[e].fs && (j == 0);
        send_beat(beat, strips[e].fixed, strips[e].want);
      end
    end

    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 60 == 0) begin
        idle_in  = $urandom_range(0, 3) != 0;
        idle_out = $urandom_range(0, 3) != 0;
      end
      beat.pixel_byte  = 8'($urandom_range(0, 255));
      beat.frame_start = (n == 0) || ($urandom_range(0, 255) == 0);
      send_beat(beat, 1'b0, 8'h00);
    end
    in_valid_i <= 1'b0;

    while (page_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
